@@ hw/rtl/ptcg_pkg.sv @@
// ----------------------------------------------------------------------------
// ptcg_pkg
// Shared widths, mapping constants and types for the tone generator.
// ----------------------------------------------------------------------------
package ptcg_pkg;

   localparam int unsigned SAMPLE_W              = 16;
   localparam int unsigned FREQ_W                = 16;
   localparam int unsigned HP_W                  = 12;
   localparam int unsigned HP_NUM_W              = 17;  // width of the tick rate
   localparam int unsigned DEN_W                 = 17;  // divisor width, 2*freq max
   localparam int unsigned DEFAULT_AVERAGE_DEPTH = 250;

   localparam logic [SAMPLE_W-1:0] LOW_KNEE        = 16'd53000;
   localparam logic [SAMPLE_W-1:0] TOP_CODE        = 16'd65535;
   localparam logic [FREQ_W-1:0]   LOW_BASE        = 16'd20;
   localparam logic [FREQ_W-1:0]   HIGH_BASE       = 16'd1000;
   // 0.01849056604 in 0.32 format
   localparam logic [26:0]         LOW_SLOPE_Q32   = 27'd79416376;
   // 3.909054647 in 2.32 format, split as integer part plus 0.32 fraction
   localparam logic [1:0]          HIGH_SLOPE_INT  = 2'd3;
   localparam logic [31:0]         HIGH_SLOPE_FRAC = 32'd3904359979;
   localparam logic [HP_NUM_W-1:0] TICK_RATE       = 17'd100000;
   localparam logic [HP_W-1:0]     HP_RESET        = 12'd2500;

   typedef struct packed {
      logic clearing;   // zeroing pass over the history still running
      logic sum_valid;  // running sum updated for the last sample
   } hist_status_type;

endpackage

@@ hw/rtl/ptcg_if.sv @@
// ----------------------------------------------------------------------------
// ptcg_req_if / ptcg_rsp_if
// Valid/ready channels for input items and result beats.
// ----------------------------------------------------------------------------
interface ptcg_req_if import ptcg_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                mode;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output mode, output sample, input ready);
   modport sink   (input valid, input mode, input sample, output ready);
endinterface

interface ptcg_rsp_if import ptcg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              buzzer_level;
   logic [FREQ_W-1:0] tone_frequency;
   logic [HP_W-1:0]   half_period_ticks;

   modport source (output valid, output buzzer_level, output tone_frequency,
                   output half_period_ticks, input ready);
   modport sink   (input valid, input buzzer_level, input tone_frequency,
                   input half_period_ticks, output ready);
endinterface

@@ hw/rtl/ptcg_div.sv @@
// ----------------------------------------------------------------------------
// ptcg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptcg_div import ptcg_pkg::*; #(
   parameter int unsigned NUM_W = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [NUM_W-1:0]             num,    // left aligned dividend
   input  logic [DEN_W-1:0]             den,
   input  logic [$clog2(NUM_W+1)-1:0]   iters,  // dividend bits to process
   output logic                         done,
   output logic [NUM_W-1:0]             quo     // quotient in the low iters bits
);

   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] q_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;

   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_sub;
   logic             fits;

   assign rem_sh  = {rem_ff, q_ff[NUM_W-1]};
   assign rem_sub = rem_sh - {1'b0, den_ff};
   assign fits    = (rem_sh >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = iters;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         q_ff   <= {q_ff[NUM_W-2:0], fits};
         rem_ff <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

@@ hw/rtl/ptcg_hist.sv @@
// ----------------------------------------------------------------------------
// ptcg_hist
// Sample history memory with running sum and write pointer.
// ----------------------------------------------------------------------------
module ptcg_hist import ptcg_pkg::*; #(
   parameter int unsigned AVERAGE_DEPTH = DEFAULT_AVERAGE_DEPTH
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      take,
   input  logic [SAMPLE_W-1:0]                       sample_in,
   output hist_status_type                           status,
   output logic [SAMPLE_W+$clog2(AVERAGE_DEPTH)-1:0] sum
);

   localparam int unsigned SUM_W = SAMPLE_W + $clog2(AVERAGE_DEPTH);
   localparam int unsigned PW    = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
   localparam logic [PW-1:0] LAST = PW'(AVERAGE_DEPTH - 1);

   logic [SAMPLE_W-1:0] mem [AVERAGE_DEPTH];

   logic                clr_ff, clr_in;
   logic [PW-1:0]       clr_ptr_ff, clr_ptr_in;
   logic [PW-1:0]       wp_ff, wp_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic                upd_ff;
   logic                sum_valid_ff;
   logic [SAMPLE_W-1:0] smp_ff;
   logic [SAMPLE_W-1:0] rd_ff;

   logic                mem_we;
   logic [PW-1:0]       mem_addr;
   logic [SAMPLE_W-1:0] mem_wdata;

   assign mem_we    = clr_ff | upd_ff;
   assign mem_addr  = clr_ff ? clr_ptr_ff : wp_ff;
   assign mem_wdata = clr_ff ? '0 : smp_ff;

   always_comb begin
      clr_in     = clr_ff;
      clr_ptr_in = clr_ptr_ff;
      wp_in      = wp_ff;
      sum_in     = sum_ff;
      if (clr_ff) begin
         clr_ptr_in = clr_ptr_ff + PW'(1);
         if (clr_ptr_ff == LAST) begin
            clr_in = 1'b0;
         end
      end
      if (upd_ff) begin
         sum_in = sum_ff - SUM_W'(rd_ff) + SUM_W'(smp_ff);
         wp_in  = (wp_ff == LAST) ? '0 : wp_ff + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= 1'b1;
         clr_ptr_ff   <= '0;
         wp_ff        <= '0;
         sum_ff       <= '0;
         upd_ff       <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         clr_ptr_ff   <= clr_ptr_in;
         wp_ff        <= wp_in;
         sum_ff       <= sum_in;
         upd_ff       <= take;
         sum_valid_ff <= upd_ff;
      end
   end

   // oldest entry is read on take, replaced in the following cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (take) begin
         rd_ff  <= mem[wp_ff];
         smp_ff <= sample_in;
      end
   end

   assign status.clearing  = clr_ff;
   assign status.sum_valid = sum_valid_ff;
   assign sum              = sum_ff;

endmodule

@@ hw/rtl/ptcg_freq_map.sv @@
// ----------------------------------------------------------------------------
// ptcg_freq_map
// Two-stage piecewise linear map from average reading to tone frequency.
// ----------------------------------------------------------------------------
module ptcg_freq_map import ptcg_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SAMPLE_W-1:0] avg,
   input  logic [FREQ_W-1:0]   freq_hold,
   output logic                done,
   output logic [FREQ_W-1:0]   freq
);

   localparam logic [1:0] SEG_KEEP = 2'd0;
   localparam logic [1:0] SEG_LOW  = 2'd1;
   localparam logic [1:0] SEG_HIGH = 2'd2;

   logic [SAMPLE_W-1:0] knee_dist;
   logic [42:0]         lo_prod;
   logic [45:0]         hi_prod;
   logic [1:0]          seg;

   logic                v1_ff;
   logic                done_ff;
   logic [1:0]          seg_ff;
   logic [10:0]         lo_ff;
   logic [13:0]         hi_ff;
   logic [13:0]         dist_ff;
   logic [FREQ_W-1:0]   freq_ff, freq_in;
   logic [FREQ_W-1:0]   dist_x3;

   assign knee_dist = avg - LOW_KNEE;
   assign lo_prod   = 43'(avg) * 43'(LOW_SLOPE_Q32);
   assign hi_prod   = 46'(knee_dist[13:0]) * 46'(HIGH_SLOPE_FRAC);

   always_comb begin
      if (avg != '0 && avg < LOW_KNEE) begin
         seg = SEG_LOW;
      end else if (avg > LOW_KNEE && avg < TOP_CODE) begin
         seg = SEG_HIGH;
      end else begin
         seg = SEG_KEEP;
      end
   end

   // integer part of the upper slope is 3
   assign dist_x3 = (FREQ_W'(dist_ff) << 1) + FREQ_W'(dist_ff) * FREQ_W'(HIGH_SLOPE_INT - 2'd2);

   always_comb begin
      case (seg_ff)
         SEG_LOW:  freq_in = LOW_BASE + FREQ_W'(lo_ff);
         SEG_HIGH: freq_in = HIGH_BASE + dist_x3 + FREQ_W'(hi_ff);
         default:  freq_in = freq_hold;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= start;
         done_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         seg_ff  <= seg;
         lo_ff   <= lo_prod[42:32];
         hi_ff   <= hi_prod[45:32];
         dist_ff <= knee_dist[13:0];
      end
      if (v1_ff) begin
         freq_ff <= freq_in;
      end
   end

   assign done = done_ff;
   assign freq = freq_ff;

endmodule

@@ hw/rtl/pot_controlled_tone_generator_unit.sv @@
// ----------------------------------------------------------------------------
// pot_controlled_tone_generator_unit
// Moving-average tone oscillator driven by potentiometer samples and ticks.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one item per beat: mode 0 is a potentiometer sample,
//   mode 1 a timer tick. rsp_bus returns exactly one beat per item with the
//   buzzer level, tone frequency and half period after that item.
//   A tick's beat is valid the cycle after accept, so ticks go back to
//   back while the receiver keeps up.
//   A sample updates the moving average, scales the running sum by a
//   constant reciprocal of AVERAGE_DEPTH, maps the average to a frequency
//   and divides 100000 by twice that frequency on the bit-serial divider,
//   which flags the finished quotient with a registered done.
//   Its beat is valid once the quotient is back; the next item is taken at
//   the edge that takes the beat, so samples are handled one at a time.
//   req_bus.ready is low meanwhile.
//   After reset the history memory is zeroed one entry per cycle, and the
//   sequencer leaves its clear state when that pass ends, before the first
//   item is taken.
//   A finished beat sits in the output register; a new item is accepted in
//   the cycle the receiver takes it, and held off while the receiver stalls.
// ----------------------------------------------------------------------------
module pot_controlled_tone_generator_unit import ptcg_pkg::*; #(
   parameter int unsigned AVERAGE_DEPTH = DEFAULT_AVERAGE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   ptcg_req_if.sink    req_bus,
   ptcg_rsp_if.source  rsp_bus
);

   localparam int unsigned SUM_W   = SAMPLE_W + $clog2(AVERAGE_DEPTH);
   localparam int unsigned DIV_W   = HP_NUM_W;
   localparam int unsigned CNT_W   = $clog2(DIV_W + 1);
   localparam int unsigned AVG_SH  = SUM_W + $clog2(AVERAGE_DEPTH);
   localparam int unsigned RECIP_W = SUM_W + 1;
   localparam int unsigned PROD_W  = SUM_W + RECIP_W;
   // ceil(2^AVG_SH / AVERAGE_DEPTH): exact floor division for any sum
   localparam logic [RECIP_W-1:0] AVG_RECIP =
      RECIP_W'(((64'd1 << AVG_SH) + 64'(AVERAGE_DEPTH) - 64'd1) / 64'(AVERAGE_DEPTH));

   // sequencer states
   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_HIST    = 3'd2;
   localparam logic [2:0] S_AVG     = 3'd3;
   localparam logic [2:0] S_MAP     = 3'd4;
   localparam logic [2:0] S_DIV_HP  = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                level_ff, level_in;
   logic [HP_W-1:0]     tick_ff, tick_in;
   logic [FREQ_W-1:0]   freq_hold_ff, freq_hold_in;
   logic [HP_W-1:0]     hp_hold_ff, hp_hold_in;
   logic [SAMPLE_W-1:0] avg_ff, avg_in;
   logic [HP_W-1:0]     tick_next;
   logic                req_fire;

   hist_status_type     hist_status;
   logic [SUM_W-1:0]    hist_sum;
   logic                hist_take;
   logic [PROD_W-1:0]   avg_prod;

   logic                div_start;
   logic [DIV_W-1:0]    div_num;
   logic [DEN_W-1:0]    div_den;
   logic [CNT_W-1:0]    div_iters;
   logic                div_done;
   logic [DIV_W-1:0]    div_quo;

   logic                map_start;
   logic                map_done;
   logic [FREQ_W-1:0]   map_freq;

   ptcg_hist #(
      .AVERAGE_DEPTH (AVERAGE_DEPTH)
   ) u_hist (
      .clock     (clock),
      .reset     (reset),
      .take      (hist_take),
      .sample_in (req_bus.sample),
      .status    (hist_status),
      .sum       (hist_sum)
   );

   // divider for the half period
   ptcg_div #(
      .NUM_W (DIV_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .iters (div_iters),
      .done  (div_done),
      .quo   (div_quo)
   );

   ptcg_freq_map u_map (
      .clock     (clock),
      .reset     (reset),
      .start     (map_start),
      .avg       (avg_ff),
      .freq_hold (freq_hold_ff),
      .done      (map_done),
      .freq      (map_freq)
   );

   // sum / AVERAGE_DEPTH by reciprocal multiplication, registered in avg_ff
   assign avg_prod = PROD_W'(hist_sum) * PROD_W'(AVG_RECIP);

   assign req_bus.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign tick_next     = tick_ff + HP_W'(1);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      level_in     = level_ff;
      tick_in      = tick_ff;
      freq_hold_in = freq_hold_ff;
      hp_hold_in   = hp_hold_ff;
      avg_in       = avg_ff;
      hist_take    = 1'b0;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;
      div_iters    = '0;
      map_start    = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            if (!hist_status.clearing) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               if (req_bus.mode) begin
                  // ">=" so a shortened half period toggles on the next tick
                  if (tick_next >= hp_hold_ff) begin
                     level_in = ~level_ff;
                     tick_in  = '0;
                  end else begin
                     tick_in = tick_next;
                  end
                  rsp_valid_in = 1'b1;
               end else begin
                  hist_take = 1'b1;
                  state_in  = S_HIST;
               end
            end
         end
         S_HIST: begin
            if (hist_status.sum_valid) begin
               avg_in   = avg_prod[AVG_SH +: SAMPLE_W];
               state_in = S_AVG;
            end
         end
         S_AVG: begin
            map_start = 1'b1;
            state_in  = S_MAP;
         end
         S_MAP: begin
            if (map_done) begin
               freq_hold_in = map_freq;
               div_start    = 1'b1;
               div_num      = DIV_W'(TICK_RATE);
               div_den      = {map_freq, 1'b0};
               div_iters    = CNT_W'(HP_NUM_W);
               state_in     = S_DIV_HP;
            end
         end
         S_DIV_HP: begin
            if (div_done) begin
               hp_hold_in   = div_quo[HP_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         level_ff     <= 1'b0;
         tick_ff      <= '0;
         freq_hold_ff <= LOW_BASE;
         hp_hold_ff   <= HP_RESET;
         avg_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         level_ff     <= level_in;
         tick_ff      <= tick_in;
         freq_hold_ff <= freq_hold_in;
         hp_hold_ff   <= hp_hold_in;
         avg_ff       <= avg_in;
      end
   end

   // holds only change after the pending beat is taken, so they are the payload
   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.buzzer_level      = level_ff;
   assign rsp_bus.tone_frequency    = freq_hold_ff;
   assign rsp_bus.half_period_ticks = hp_hold_ff;

   // a tick beat is ready the cycle after it is accepted
   a_tick_latency: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_bus.mode) |=> rsp_valid_ff)
      else $error("tick beat not presented after accept");

   // divider finishes only while the sequencer waits on it
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV_HP))
      else $error("divider done outside a divide step");

   // half period stays in its legal range
   a_hp_range: assert property (@(posedge clock) disable iff (reset)
      (hp_hold_ff >= HP_W'(1)) && (hp_hold_ff <= HP_RESET))
      else $error("half period out of range");

   // frequency stays within the mapped range
   a_freq_range: assert property (@(posedge clock) disable iff (reset)
      (freq_hold_ff >= LOW_BASE) && (freq_hold_ff <= 16'd49996))
      else $error("tone frequency out of range");

endmodule
